// File: hw/rtl/xcfp_pkg.sv
`default_nettype none

package xcfp_pkg;

  localparam logic [7:0] START_BYTE = 8'hFE;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_LEN    = 3'd1,
    PH_ROOM   = 3'd2,
    PH_PARAM  = 3'd3,
    PH_VALUES = 3'd4,
    PH_CHECK  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_PARAM = 2'd1,
    KIND_ACK   = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef struct packed {
    logic [8:0] body_length;
    logic [7:0] param_index;
    logic [8:0] position;
    logic [7:0] data;
    kind_e      kind;
  } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/xor_checked_frame_parser.sv
`default_nettype none

// Frame parser for an XOR-checked byte stream. It hunts for the start byte 0xFE, then takes
// the length byte, room index, parameter index, the value bytes and one check byte. Every body
// byte leaves as an item of kind body with its position (the length byte is position 0); the
// check byte leaves as a verdict item (good parameter frame, good ack frame when the parameter
// index matches the configured ack index, or checksum error) carrying the check byte, the
// frame's parameter index and its body length. Start bytes and idle bytes produce nothing.
// One byte is taken every cycle unless the skid register is full; parse state and results
// are registered as each byte is taken. An output register plus a one-item skid register
// let input continue while a result waits; input stalls only when both hold an item. The
// ack index is written through the cfg channel; the user must do so while idle (not enforced).
module xor_checked_frame_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] body_byte, [16:8] body_position,
                                           // [24:17] frame_param_index,
                                           // [33:25] frame_body_length, [39:34] zero
  output logic [1:0]       m_axis_tuser,   // [1:0] result_kind
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i
);
  import xcfp_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] xor_q, xor_d;
  logic [8:0] count_q, count_d;
  logic [7:0] left_q, left_d;
  logic [7:0] param_q, param_d;
  logic [7:0] ack_q;

  result_t    res;
  logic       has_res;
  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       in_fire, out_fire, new_res;

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;
  assign new_res       = in_fire && has_res;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    phase_d = phase_q;
    xor_d   = xor_q;
    count_d = count_q;
    left_d  = left_q;
    param_d = param_q;
    has_res = 1'b0;
    res     = '{body_length: 9'd0, param_index: 8'd0, position: 9'd0,
                data: s_axis_tdata, kind: KIND_BODY};
    unique case (phase_q)
      PH_LEN, PH_ROOM, PH_PARAM, PH_VALUES: begin
        has_res      = 1'b1;
        res.position = count_q;
        xor_d        = xor_q ^ s_axis_tdata;
        count_d      = count_q + 9'd1;
        if (phase_q == PH_LEN) begin
          left_d  = s_axis_tdata;
          phase_d = PH_ROOM;
        end else if (phase_q == PH_ROOM) begin
          phase_d = PH_PARAM;
        end else if (phase_q == PH_PARAM) begin
          param_d = s_axis_tdata;
          phase_d = (left_q == 8'd0) ? PH_CHECK : PH_VALUES;
        end else begin
          left_d = (left_q != 8'd0) ? left_q - 8'd1 : 8'd0;
          if (left_d == 8'd0) begin
            phase_d = PH_CHECK;
          end
        end
      end
      PH_CHECK: begin
        has_res         = 1'b1;
        res.param_index = param_q;
        res.body_length = count_q;
        if (xor_q != s_axis_tdata) begin
          res.kind = KIND_ERROR;
        end else if (param_q == ack_q) begin
          res.kind = KIND_ACK;
        end else begin
          res.kind = KIND_PARAM;
        end
        phase_d = PH_WAIT;
      end
      default: begin
        // Waiting for the start byte; unused codes fall back here too.
        phase_d = PH_WAIT;
        if (s_axis_tdata == START_BYTE) begin
          xor_d   = 8'd0;
          count_d = 9'd0;
          phase_d = PH_LEN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      xor_q   <= 8'd0;
      count_q <= 9'd0;
      left_q  <= 8'd0;
      param_q <= 8'd0;
      ack_q   <= 8'd0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        xor_q   <= xor_d;
        count_q <= count_d;
        left_q  <= left_d;
        param_q <= param_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        ack_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (new_res) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers follow the same steering as the valid bits above.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (new_res) begin
      if (!out_valid_q || out_fire) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {6'd0, out_q.body_length, out_q.param_index, out_q.position,
                          out_q.data};

`ifndef SYNTH
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds an item while the output register is empty");

  a_check_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && phase_q == PH_CHECK) |=> (phase_q == PH_WAIT))
    else $error("parser did not return to hunting after the check byte");

  a_verdict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != KIND_BODY) |-> (m_axis_tdata[16:8] == 9'd0))
    else $error("verdict item carries a nonzero body position");

  a_body_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_BODY) |-> (m_axis_tdata[33:17] == 17'd0))
    else $error("body item carries verdict fields");
`endif

endmodule

`default_nettype wire
